>>> src/ffge_pkg.sv
// ----------------------------------------------------------------------------
// ffge_pkg
// Shared types and constants of the forest fire grid engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ffge_pkg;

  localparam int MAX_SIDE_DEF = 128;
  localparam logic [7:0] GRID_SIDE_RESET = 8'd100;
  localparam logic [15:0] COUNT_LIMIT = 16'hFFFF;

  typedef enum logic [1:0] {
    CELL_EMPTY   = 2'd0,
    CELL_TREE    = 2'd1,
    CELL_BURNING = 2'd2,
    CELL_BURNT   = 2'd3
  } cell_e;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_IGN_RD,
    ST_IGN_WR,
    ST_ROW_RD,
    ST_CELL_RD,
    ST_CELL_DN,
    ST_CELL_WR
  } state_e;

  typedef struct packed {
    logic [1:0]  read_value;
    logic [15:0] generation_count;
    logic        bottom_hit;
  } result_t;

endpackage

`default_nettype wire

>>> src/ffge_ram.sv
// ----------------------------------------------------------------------------
// ffge_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ffge_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16384,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/ffge_engine.sv
// ----------------------------------------------------------------------------
// ffge_engine
// Command sequencer: cell write/read, top row ignition and generation sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module ffge_engine #(
  parameter int MAX_SIDE = ffge_pkg::MAX_SIDE_DEF,
  localparam int IDX_W  = $clog2(MAX_SIDE),
  localparam int SIDE_W = $clog2(MAX_SIDE + 1),
  localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        grid_side,
  // input word
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        command,
  input  wire logic [6:0]        cell_row,
  input  wire logic [6:0]        cell_col,
  input  wire logic [1:0]        cell_value,
  // result slot
  input  wire logic              out_free,
  output logic                   res_valid,
  output ffge_pkg::result_t      res,
  // cell store
  output logic                   a_we,
  output logic [ADDR_W-1:0]      a_waddr,
  output logic [1:0]             a_wdata,
  output logic [ADDR_W-1:0]      a_raddr,
  input  wire logic [1:0]        a_rdata,
  // old values of the row above
  output logic                   b_we,
  output logic [IDX_W-1:0]       b_addr,
  output logic [1:0]             b_wdata,
  input  wire logic [1:0]        b_rdata
);

  localparam int CMP_W = (SIDE_W > 8) ? SIDE_W : 8;
  localparam int IN_W  = (SIDE_W > 7) ? SIDE_W : 7;

  ffge_pkg::state_e state, state_next;

  logic [IDX_W-1:0] r, c;
  logic [1:0]       cur, left, right, up;
  logic             first;
  logic             lit, bottom;
  logic [15:0]      cnt;
  logic             rd_inside;

  logic [CMP_W-1:0]  gs_ext;
  logic [SIDE_W-1:0] n, n_m1;
  logic              c_last, r_last, in_grid, acc;
  logic [IDX_W-1:0]  col_rd, row_dn;
  logic [1:0]        cur_eff, down, cell_new;
  logic              hot, lit_now, lit_next, bottom_next;
  logic [15:0]       cnt_inc;
  logic [ADDR_W-1:0] addr_in;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [31:0] row,
                                                  input logic [31:0] col);
    logic [31:0] a;
    a = row * 32'(MAX_SIDE) + col;
    return a[ADDR_W-1:0];
  endfunction

  // side in use: 0 acts as 1, anything above MAX_SIDE clamps
  always_comb begin
    gs_ext = CMP_W'(grid_side);
    if (gs_ext == '0) begin
      n = SIDE_W'(1);
    end else if (gs_ext > CMP_W'(MAX_SIDE)) begin
      n = SIDE_W'(MAX_SIDE);
    end else begin
      n = SIDE_W'(gs_ext);
    end
  end

  assign n_m1    = n - SIDE_W'(1);
  assign c_last  = (SIDE_W'(c) == n_m1);
  assign r_last  = (SIDE_W'(r) == n_m1);
  assign in_grid = (IN_W'(cell_row) < IN_W'(n)) && (IN_W'(cell_col) < IN_W'(n));
  assign addr_in = cell_addr(32'(cell_row), 32'(cell_col));
  assign acc     = in_valid && in_ready;
  assign in_ready = (state == ffge_pkg::ST_IDLE) && out_free;

  assign col_rd = c_last ? c : IDX_W'(c + 1'b1);
  assign row_dn = r_last ? r : IDX_W'(r + 1'b1);

  // cell update, evaluated in ST_CELL_WR
  assign cur_eff = first ? a_rdata : cur;
  assign down    = r_last ? ffge_pkg::CELL_EMPTY : a_rdata;
  assign hot     = (up == ffge_pkg::CELL_BURNING) || (down == ffge_pkg::CELL_BURNING) ||
                   (left == ffge_pkg::CELL_BURNING) || (right == ffge_pkg::CELL_BURNING);

  always_comb begin
    lit_now = 1'b0;
    case (cur)
      ffge_pkg::CELL_BURNING: cell_new = ffge_pkg::CELL_BURNT;
      ffge_pkg::CELL_TREE: begin
        if (hot) begin
          cell_new = ffge_pkg::CELL_BURNING;
          lit_now  = 1'b1;
        end else begin
          cell_new = cur;
        end
      end
      default: cell_new = cur;
    endcase
  end

  assign lit_next    = lit | lit_now;
  assign bottom_next = bottom | (r_last & cell_new[1]);
  assign cnt_inc     = (cnt == ffge_pkg::COUNT_LIMIT) ? cnt : cnt + 16'd1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffge_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (command)
            ffge_pkg::CMD_READ: state_next = ffge_pkg::ST_READ;
            ffge_pkg::CMD_RUN:  state_next = ffge_pkg::ST_IGN_RD;
            default:            state_next = ffge_pkg::ST_IDLE;
          endcase
        end
      end
      ffge_pkg::ST_READ:    state_next = ffge_pkg::ST_IDLE;
      ffge_pkg::ST_IGN_RD:  state_next = ffge_pkg::ST_IGN_WR;
      ffge_pkg::ST_IGN_WR:  state_next = c_last ? ffge_pkg::ST_ROW_RD : ffge_pkg::ST_IGN_RD;
      ffge_pkg::ST_ROW_RD:  state_next = ffge_pkg::ST_CELL_RD;
      ffge_pkg::ST_CELL_RD: state_next = ffge_pkg::ST_CELL_DN;
      ffge_pkg::ST_CELL_DN: state_next = ffge_pkg::ST_CELL_WR;
      ffge_pkg::ST_CELL_WR: begin
        if (!c_last) begin
          state_next = ffge_pkg::ST_CELL_RD;
        end else if (!r_last || lit_next) begin
          state_next = ffge_pkg::ST_ROW_RD;
        end else begin
          state_next = ffge_pkg::ST_IDLE;
        end
      end
      default: state_next = ffge_pkg::ST_IDLE;
    endcase
  end

  // outputs: memory requests and result
  always_comb begin
    a_we      = 1'b0;
    a_waddr   = addr_in;
    a_wdata   = cell_value;
    a_raddr   = addr_in;
    b_we      = 1'b0;
    b_addr    = c;
    b_wdata   = cur;
    res_valid = 1'b0;
    res       = '0;
    unique case (state)
      ffge_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (command) inside
            ffge_pkg::CMD_WRITE: begin
              a_we      = in_grid;
              res_valid = 1'b1;
            end
            ffge_pkg::CMD_READ, ffge_pkg::CMD_RUN: ;
            default: res_valid = 1'b1;
          endcase
        end
      end
      ffge_pkg::ST_READ: begin
        res_valid      = 1'b1;
        res.read_value = rd_inside ? a_rdata : 2'd0;
      end
      ffge_pkg::ST_IGN_RD: begin
        a_raddr = cell_addr(32'd0, 32'(c));
      end
      ffge_pkg::ST_IGN_WR: begin
        a_waddr = cell_addr(32'd0, 32'(c));
        a_wdata = ffge_pkg::CELL_BURNING;
        a_we    = (a_rdata == ffge_pkg::CELL_TREE);
      end
      ffge_pkg::ST_ROW_RD: begin
        a_raddr = cell_addr(32'(r), 32'd0);
      end
      ffge_pkg::ST_CELL_RD: begin
        a_raddr = cell_addr(32'(r), 32'(col_rd));
      end
      ffge_pkg::ST_CELL_DN: begin
        a_raddr = cell_addr(32'(row_dn), 32'(c));
      end
      ffge_pkg::ST_CELL_WR: begin
        a_waddr = cell_addr(32'(r), 32'(c));
        a_wdata = cell_new;
        a_we    = (cell_new != cur);
        b_we    = 1'b1;
        if (c_last && r_last && !lit_next) begin
          res_valid            = 1'b1;
          res.generation_count = cnt_inc;
          res.bottom_hit       = bottom_next;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffge_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sweep registers
  always_ff @(posedge clk) begin
    unique case (state)
      ffge_pkg::ST_IDLE: begin
        if (acc) begin
          rd_inside <= in_grid;
          r         <= '0;
          c         <= '0;
        end
      end
      ffge_pkg::ST_IGN_WR: begin
        if (c_last) begin
          r      <= '0;
          c      <= '0;
          cnt    <= '0;
          lit    <= 1'b0;
          bottom <= 1'b0;
        end else begin
          c <= IDX_W'(c + 1'b1);
        end
      end
      ffge_pkg::ST_ROW_RD: begin
        left  <= ffge_pkg::CELL_EMPTY;
        first <= 1'b1;
      end
      ffge_pkg::ST_CELL_RD: begin
        cur   <= cur_eff;
        first <= 1'b0;
      end
      ffge_pkg::ST_CELL_DN: begin
        right <= c_last ? ffge_pkg::CELL_EMPTY : a_rdata;
        up    <= (r == '0) ? ffge_pkg::CELL_EMPTY : b_rdata;
      end
      ffge_pkg::ST_CELL_WR: begin
        left <= cur;
        cur  <= right;
        c    <= c_last ? '0 : IDX_W'(c + 1'b1);
        if (c_last && r_last) begin
          // generation done: restart the sweep flags
          r      <= '0;
          cnt    <= cnt_inc;
          lit    <= 1'b0;
          bottom <= 1'b0;
        end else begin
          lit    <= lit_next;
          bottom <= bottom_next;
          if (c_last) begin
            r <= IDX_W'(r + 1'b1);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/forest_fire_grid_engine.sv
// ----------------------------------------------------------------------------
// forest_fire_grid_engine
// Forest fire cellular automaton over a square grid held in on-chip memory.
// ----------------------------------------------------------------------------
// Every input word yields exactly one result word. A cell write is answered in
// the cycle that accepts it and a cell read from ST_READ. A run first lights
// the trees of the top row and then sweeps generations over the side in use;
// it ends after the first generation that lights no tree. Each cell is swept
// in the states ST_CELL_RD, ST_CELL_DN and ST_CELL_WR because the cell store
// has a single read port: the cell to the right and the cell below are fetched
// one after the other; the new state is written back in ST_CELL_WR. Old states
// of the row above sit in a small row memory so the update is truly
// synchronous in place. A result register decouples the output side, so a new
// word can be taken in the same cycle as a waiting result is drained. The cell
// store is not cleared at reset; cells must be written before they are read
// or swept.
// ----------------------------------------------------------------------------
`default_nettype none

module forest_fire_grid_engine #(
  parameter int MAX_SIDE = ffge_pkg::MAX_SIDE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: grid_side
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  // command word
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // cell_row[6:0], cell_col[13:7], cell_value[15:14]
  input  wire logic [1:0]  s_axis_tuser,   // command[1:0]
  // result word
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // read_value[1:0], generation_count[17:2],
                                           // bottom_hit[18], zero[23:19]
);

  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);

  logic [7:0] grid_side;

  // result register
  logic              out_valid;
  ffge_pkg::result_t out_word;
  logic              out_free;

  logic              res_valid;
  ffge_pkg::result_t res;

  // cell store ports
  logic              a_we;
  logic [ADDR_W-1:0] a_waddr, a_raddr;
  logic [1:0]        a_wdata, a_rdata;

  // row-above memory ports
  logic              b_we;
  logic [IDX_W-1:0]  b_addr;
  logic [1:0]        b_wdata, b_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= ffge_pkg::GRID_SIDE_RESET;
    end else if (cfg_wr_en) begin
      grid_side <= cfg_wr_data;
    end
  end

  ffge_engine #(
    .MAX_SIDE (MAX_SIDE)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .grid_side  (grid_side),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .command    (s_axis_tuser),
    .cell_row   (s_axis_tdata[6:0]),
    .cell_col   (s_axis_tdata[13:7]),
    .cell_value (s_axis_tdata[15:14]),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res),
    .a_we       (a_we),
    .a_waddr    (a_waddr),
    .a_wdata    (a_wdata),
    .a_raddr    (a_raddr),
    .a_rdata    (a_rdata),
    .b_we       (b_we),
    .b_addr     (b_addr),
    .b_wdata    (b_wdata),
    .b_rdata    (b_rdata)
  );

  // grid cells, row-major with a stride of MAX_SIDE
  ffge_ram #(
    .WIDTH (2),
    .DEPTH (MAX_SIDE * MAX_SIDE)
  ) u_cell_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // pre-update states of the previous row; entries are always written
  // before a sweep reads them, row zero masks the read
  ffge_ram #(
    .WIDTH (2),
    .DEPTH (MAX_SIDE)
  ) u_row_above (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_addr),
    .wdata (b_wdata),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  // the engine only takes a word when the slot is free by the next edge, and
  // a later result (read, run) is loaded only after that slot has drained
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_word <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_word.bottom_hit, out_word.generation_count,
                          out_word.read_value};

endmodule

`default_nettype wire
